>>> rtl/wnfm_pkg.sv
package wnfm_pkg;

  // Operation codes carried in the input word's tuser field.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_SEARCH_RADIUS = 2'd0;
  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd1;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd2;

  // Register reset values.
  localparam logic [2:0] SEARCH_RADIUS_RST = 3'd3;
  localparam logic [9:0] FRAME_WIDTH_RST   = 10'd240;
  localparam logic [8:0] FRAME_HEIGHT_RST  = 9'd180;

  // Distance that stands for "nothing found yet".
  localparam int NO_DIST_W = 15;
  localparam logic [NO_DIST_W-1:0] NO_DIST = 15'd30000;

  typedef logic [15:0] depth_t;

endpackage

>>> rtl/windowed_nearest_feature_match.sv
// Windowed nearest feature match. The block holds a depth map of MAX_WIDTH by
// MAX_HEIGHT 16-bit entries in one memory with one read and one write port,
// where zero means an
// empty pixel. Each input word carries an operation in tuser: a clear empties
// the whole map, a write stores a depth at a pixel if that pixel is inside the
// configured frame and still empty, and a query scans the square window of the
// configured radius around a pixel, clipped to the frame, and returns the
// nearest stored entry by squared distance (ties go to the first entry in
// raster order) or an unmatched result. Only queries produce an output word.
// The block takes one word at a time and holds s_axis_tready low while it
// works. A clear sweeps all MAX_WIDTH * MAX_HEIGHT map entries at one entry
// per cycle; the same clearing pass runs after reset before the first word is
// accepted. A write reads the entry, then conditionally writes the same
// entry. A query scans the clipped window row by row; the map's single read
// port delivers one entry per cycle and the shared square-and-compare unit
// handles one candidate per cycle, with a row step before each row to square
// the row offset. A finished result waits in an output register, so the next
// word can be accepted while the result has not yet been taken.
// Configuration writes are taken at any time but must only be issued while the
// block is idle.
module windowed_nearest_feature_match #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 7
) (
  input  logic        clk,
  input  logic        rst,

  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,

  // Input words.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // pixel_x[8:0], pixel_y[16:9], depth_in[32:17]
  input  logic [1:0]  s_axis_tuser,   // op[1:0]

  // Result words.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // match_x[8:0], match_y[16:9], match_depth[32:17]
  output logic [0:0]  m_axis_tuser    // matched[0]
);

  import wnfm_pkg::*;

  localparam int MAP_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(MAP_DEPTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  // Signed coordinate widths: room for the frame size and for pixel plus radius.
  localparam int CW = ((WW > 10) ? WW : 10) + 1;
  localparam int CH = ((HW > 9) ? HW : 9) + 1;
  // Signed offset width inside the window, and width of a squared distance.
  localparam int SW = $clog2(MAX_RADIUS + 1) + 1;
  localparam int DW = 2 * SW;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_WRD    = 4'd2;
  localparam logic [3:0] S_WCHK   = 4'd3;
  localparam logic [3:0] S_QSET   = 4'd4;
  localparam logic [3:0] S_QROW   = 4'd5;
  localparam logic [3:0] S_QSCAN  = 4'd6;
  localparam logic [3:0] S_QDRAIN = 4'd7;
  localparam logic [3:0] S_DONE   = 4'd8;

  // Configuration registers.
  logic [2:0] search_radius;
  logic [9:0] frame_width;
  logic [8:0] frame_height;

  logic [3:0] state;

  // Latched input word.
  logic [8:0] in_x;
  logic [7:0] in_y;
  depth_t     in_depth;

  // Map memory.
  depth_t        mem [MAP_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  depth_t        mem_wdata;
  logic [AW-1:0] mem_raddr;
  depth_t        rd_data;

  logic [AW-1:0] clear_addr;
  logic [AW-1:0] wr_addr;

  // Window scan registers.
  logic signed [CW-1:0] x0, x1, cx;
  logic signed [CH-1:0] y1, cy;
  logic [AW-1:0]        row_base;
  logic [DW-1:0]        dy_sq;

  // Candidate in flight, aligned with the registered read data.
  logic                 p_valid;
  logic signed [CW-1:0] p_x;
  logic signed [CH-1:0] p_y;
  logic [DW-1:0]        p_dist;

  // Best match so far.
  logic                 found;
  logic [NO_DIST_W-1:0] best;
  logic signed [CW-1:0] bx;
  logic signed [CH-1:0] by;
  depth_t               bd;

  // Saturated frame and radius.
  logic [WW-1:0]        eff_w;
  logic [HW-1:0]        eff_h;
  logic [2:0]           radius_sat;
  logic signed [CW-1:0] w_s, px_s, rx_s, xlo, xhi;
  logic signed [CH-1:0] h_s, py_s, ry_s, ylo, yhi;
  logic                 in_frame;

  // Shared squaring unit.
  logic signed [CW-1:0] dx_full;
  logic signed [CH-1:0] dy_full;
  logic signed [SW-1:0] sq_in;
  logic signed [DW-1:0] sq;
  logic [DW-1:0]        cand_dist;
  logic                 take;

  logic in_acc;
  logic out_load;

  assign eff_w = (int'(frame_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(frame_width);
  assign eff_h = (int'(frame_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(frame_height);
  assign radius_sat = (int'(search_radius) > MAX_RADIUS) ? 3'(MAX_RADIUS) : search_radius;

  assign w_s  = $signed(CW'(eff_w));
  assign h_s  = $signed(CH'(eff_h));
  assign px_s = $signed(CW'(in_x));
  assign py_s = $signed(CH'(in_y));
  assign rx_s = $signed(CW'(radius_sat));
  assign ry_s = $signed(CH'(radius_sat));

  // Window bounds clipped to the frame.
  always_comb begin
    xlo = px_s - rx_s;
    if (xlo < 0) begin
      xlo = '0;
    end
    xhi = px_s + rx_s;
    if (xhi > w_s - CW'(1)) begin
      xhi = w_s - CW'(1);
    end
    ylo = py_s - ry_s;
    if (ylo < 0) begin
      ylo = '0;
    end
    yhi = py_s + ry_s;
    if (yhi > h_s - CH'(1)) begin
      yhi = h_s - CH'(1);
    end
  end

  assign in_frame = (px_s < w_s) && (py_s < h_s);

  // The row offset is squared at the start of each row and the column offset
  // on every scan cycle, through the same multiplier.
  assign dx_full   = cx - px_s;
  assign dy_full   = cy - py_s;
  assign sq_in     = (state == S_QROW) ? dy_full[SW-1:0] : dx_full[SW-1:0];
  assign sq        = DW'(sq_in) * DW'(sq_in);
  assign cand_dist = dy_sq + $unsigned(sq);

  // A candidate replaces the best only when strictly nearer, which keeps the
  // first one in raster order among equals.
  assign take = p_valid && (rd_data != '0) && (NO_DIST_W'(p_dist) < best);

  assign s_axis_tready = (state == S_IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_load = (state == S_DONE) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      search_radius <= SEARCH_RADIUS_RST;
      frame_width   <= FRAME_WIDTH_RST;
      frame_height  <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEARCH_RADIUS: search_radius <= cfg_data[2:0];
        REG_FRAME_WIDTH:   frame_width   <= cfg_data;
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Memory port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clear_addr;
    mem_wdata = '0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_WCHK && rd_data == '0) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr;
      mem_wdata = in_depth;
    end
  end

  assign mem_raddr = (state == S_WRD)
                   ? (AW'(MAX_WIDTH) * AW'(in_y) + AW'(in_x))
                   : (row_base + AW'(cx));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clear_addr <= '0;
      p_valid    <= 1'b0;
      found      <= 1'b0;
    end else begin
      p_valid <= (state == S_QSCAN);
      case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (clear_addr == AW'(MAP_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            in_x     <= s_axis_tdata[8:0];
            in_y     <= s_axis_tdata[16:9];
            in_depth <= s_axis_tdata[32:17];
            case (s_axis_tuser)
              OP_CLEAR: begin
                clear_addr <= '0;
                state      <= S_CLEAR;
              end
              OP_WRITE: state <= S_WRD;
              OP_QUERY: state <= S_QSET;
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_WRD: begin
          wr_addr <= mem_raddr;
          state   <= in_frame ? S_WCHK : S_IDLE;
        end
        S_WCHK: begin
          state <= S_IDLE;
        end
        S_QSET: begin
          x0    <= xlo;
          x1    <= xhi;
          y1    <= yhi;
          cy    <= ylo;
          found <= 1'b0;
          best  <= NO_DIST;
          bx    <= '0;
          by    <= '0;
          bd    <= '0;
          state <= (xlo > xhi || ylo > yhi) ? S_DONE : S_QROW;
        end
        S_QROW: begin
          row_base <= AW'(MAX_WIDTH) * AW'(cy);
          dy_sq    <= $unsigned(sq);
          cx       <= x0;
          state    <= S_QSCAN;
        end
        S_QSCAN: begin
          p_x    <= cx;
          p_y    <= cy;
          p_dist <= cand_dist;
          if (cx == x1) begin
            if (cy == y1) begin
              state <= S_QDRAIN;
            end else begin
              cy    <= cy + 1'b1;
              state <= S_QROW;
            end
          end else begin
            cx <= cx + 1'b1;
          end
        end
        S_QDRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // The compare of the last fetched candidate lands in the cycle after
      // its read, whatever state the sequencer has moved on to.
      if (take) begin
        found <= 1'b1;
        best  <= NO_DIST_W'(p_dist);
        bx    <= p_x;
        by    <= p_y;
        bd    <= rd_data;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tuser <= found;
      m_axis_tdata <= {7'd0, bd, by[7:0], bx[8:0]};
    end
  end

  // A new result only appears after the sequencer has finished a query.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    ($rose(m_axis_tvalid) |-> $past(state) == S_DONE))
    else $error("result word loaded outside the done state");

  // An unmatched result carries zero coordinates and depth.
  a_unmatched_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0))
    else $error("unmatched result with nonzero payload");

  // A matched result always points at an occupied pixel.
  a_matched_depth: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[32:17] != '0))
    else $error("matched result with zero depth");

  // The column pointer stays inside the clipped window while scanning.
  a_scan_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_QSCAN |-> cx >= x0 && cx <= x1))
    else $error("scan column outside the window");

  // Once something is found, the kept distance is a real one.
  a_best_valid: assert property (@(posedge clk) disable iff (rst)
    (found |-> best < NO_DIST))
    else $error("match flagged without a valid distance");

endmodule
